// ===== design/tlpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpc_pkg
// Shared types, register map and lamp encodings for the two-way traffic
// light phase controller.
// ----------------------------------------------------------------------------
package tlpc_pkg;

  localparam int unsigned CNT_W   = 5;
  localparam int unsigned YEL_W   = 2;
  localparam int unsigned LAMP_W  = 6;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_SOUTH_RED = 2'd0;
  localparam logic [1:0] REG_SOUTH_GO  = 2'd1;
  localparam logic [1:0] REG_YELLOW    = 2'd2;

  localparam logic [CNT_W-1:0] SOUTH_RED_RST = 5'd23;
  localparam logic [CNT_W-1:0] SOUTH_GO_RST  = 5'd15;
  localparam logic [YEL_W-1:0] YELLOW_RST    = 2'd3;

  // lamp patterns, one per phase
  localparam logic [LAMP_W-1:0] LAMPS_W_YELLOW = 6'b010001;
  localparam logic [LAMP_W-1:0] LAMPS_W_GREEN  = 6'b100001;
  localparam logic [LAMP_W-1:0] LAMPS_S_YELLOW = 6'b001010;
  localparam logic [LAMP_W-1:0] LAMPS_S_GREEN  = 6'b001100;

  typedef struct packed {
    logic [1:0]       phase;
    logic [CNT_W-1:0] half_cnt;
    logic [CNT_W-1:0] other_cnt;
    logic             running_auto;
    logic [YEL_W-1:0] man_cnt;
  } tlpc_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] south_red_sec;
    logic [CNT_W-1:0] south_go_sec;
    logic [YEL_W-1:0] yellow_sec;
  } tlpc_cfg_t;

  typedef struct packed {
    logic [LAMP_W-1:0] lamps;
    logic [CNT_W-1:0]  south_count;
    logic [CNT_W-1:0]  west_count;
    logic              display_on;
  } tlpc_result_t;

  function automatic logic [LAMP_W-1:0] phase_lamps(input logic [1:0] phase);
    logic [LAMP_W-1:0] l;
    case (phase)
      2'd0:    l = LAMPS_W_YELLOW;
      2'd1:    l = LAMPS_W_GREEN;
      2'd2:    l = LAMPS_S_YELLOW;
      2'd3:    l = LAMPS_S_GREEN;
      default: l = LAMPS_W_YELLOW;
    endcase
    return l;
  endfunction

endpackage

// ===== design/tlpc_ifs.sv =====
// ----------------------------------------------------------------------------
// tlpc channel interfaces
// Valid/ready channels for input events and controller results.
// ----------------------------------------------------------------------------
interface tlpc_in_if (input logic clk);
  logic valid;
  logic ready;
  logic action;
  logic auto_switch;

  modport source (output valid, action, auto_switch, input ready);
  modport sink   (input valid, action, auto_switch, output ready);
endinterface

interface tlpc_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [5:0] lamps;
  logic [4:0] south_count;
  logic [4:0] west_count;
  logic       display_on;

  modport source (output valid, lamps, south_count, west_count, display_on, input ready);
  modport sink   (input valid, lamps, south_count, west_count, display_on, output ready);
endinterface

// ===== design/tlpc_next.sv =====
// ----------------------------------------------------------------------------
// tlpc_next
// Next-state and result logic for one event (tick or button press).
// ----------------------------------------------------------------------------
module tlpc_next (
  input  tlpc_pkg::tlpc_state_t  state_i,
  input  tlpc_pkg::tlpc_cfg_t    cfg_i,
  input  logic                   action_i,
  input  logic                   auto_i,
  output tlpc_pkg::tlpc_state_t  state_o,
  output tlpc_pkg::tlpc_result_t result_o
);
  import tlpc_pkg::*;

  // begin a half cycle; second selects the south-go half
  function automatic tlpc_state_t start_half(input tlpc_state_t s_in, input logic second,
                                             input tlpc_cfg_t c);
    tlpc_state_t s;
    s          = s_in;
    s.phase    = second ? 2'd2 : 2'd0;
    s.half_cnt = second ? c.south_go_sec : c.south_red_sec;
    s.other_cnt = {{(CNT_W-YEL_W){1'b0}}, c.yellow_sec};
    if (c.yellow_sec == '0) begin
      s.phase     = {s.phase[1], 1'b1};
      s.other_cnt = s.half_cnt;
    end
    return s;
  endfunction

  tlpc_state_t      s;
  logic [CNT_W-1:0] south;
  logic [CNT_W-1:0] west;
  logic             lit;

  always_comb begin
    s     = state_i;
    south = '0;
    west  = '0;
    lit   = 1'b0;
    if (auto_i) begin
      if (!s.running_auto) begin
        s              = start_half(s, 1'b0, cfg_i);
        s.running_auto = 1'b1;
        s.man_cnt      = '0;
      end else if (!action_i) begin
        if (s.half_cnt <= 5'd1) begin
          s = start_half(s, ~s.phase[1], cfg_i);
        end else begin
          s.half_cnt = s.half_cnt - 5'd1;
          if (s.other_cnt != '0) begin
            s.other_cnt = s.other_cnt - 5'd1;
          end
          // yellow expired: go green, other display follows the half cycle
          if (!s.phase[0] && s.other_cnt == '0) begin
            s.phase     = {s.phase[1], 1'b1};
            s.other_cnt = s.half_cnt;
          end
        end
      end
      if (!s.phase[1]) begin
        south = s.half_cnt;
        west  = s.other_cnt;
      end else begin
        south = s.other_cnt;
        west  = s.half_cnt;
      end
      lit = 1'b1;
    end else begin
      if (s.running_auto) begin
        s.running_auto = 1'b0;
      end else if (s.man_cnt != '0) begin
        if (!action_i) begin
          s.man_cnt = s.man_cnt - 2'd1;
          if (s.man_cnt == '0) begin
            s.phase = s.phase + 2'd1;
          end
        end
      end else if (s.phase[0]) begin
        if (action_i) begin
          s.phase = s.phase + 2'd1;
        end
      end
      // arriving on a yellow phase starts its countdown, or goes on to green if the yellow time is zero
      if (s.man_cnt == '0 && !s.phase[0]) begin
        if (cfg_i.yellow_sec == '0) begin
          s.phase = s.phase + 2'd1;
        end else begin
          s.man_cnt = cfg_i.yellow_sec;
        end
      end
      if (s.man_cnt != '0) begin
        south = {{(CNT_W-YEL_W){1'b0}}, s.man_cnt};
        west  = {{(CNT_W-YEL_W){1'b0}}, s.man_cnt};
        lit   = 1'b1;
      end
    end
  end

  assign state_o              = s;
  assign result_o.lamps       = phase_lamps(s.phase);
  assign result_o.south_count = south;
  assign result_o.west_count  = west;
  assign result_o.display_on  = lit;

endmodule

// ===== design/traffic_light_phase_controller.sv =====
// ----------------------------------------------------------------------------
// traffic_light_phase_controller
// Two-way crossing controller: four lamp phases, per-street countdowns,
// automatic and manual modes, APB-style timing registers.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in_ch     in         valid/ready          action, auto_switch
//  out_ch    out        valid/ready          lamps, south_count, west_count,
//                                            display_on
//  cfg (APB) in         psel/penable/pwrite  paddr[3:2] index, pwdata
//
// One transaction in, one result out. Each event is handled by the combinational
// next-state logic and lands in the output register the next cycle.
// A new transaction is taken every cycle while the output register is empty
// or being drained; a stalled output holds the input off.
// Synchronous active-low reset clears the controller state and loads the
// register defaults (23, 15, 3).
// ----------------------------------------------------------------------------
module traffic_light_phase_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  tlpc_in_if.sink                        in_ch,
  tlpc_out_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tlpc_pkg::PADDR_W-1:0]   paddr,
  input  logic [tlpc_pkg::PDATA_W-1:0]   pwdata,
  output logic [tlpc_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import tlpc_pkg::*;

  tlpc_cfg_t    cfg_r;
  tlpc_state_t  state_r;
  tlpc_state_t  state_nxt;
  tlpc_result_t result_nxt;
  tlpc_result_t result_r;
  logic         out_valid_r;
  logic         in_fire;
  logic         cfg_wr;
  logic [1:0]   reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.south_red_sec <= SOUTH_RED_RST;
      cfg_r.south_go_sec  <= SOUTH_GO_RST;
      cfg_r.yellow_sec    <= YELLOW_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SOUTH_RED: cfg_r.south_red_sec <= pwdata[CNT_W-1:0];
        REG_SOUTH_GO:  cfg_r.south_go_sec  <= pwdata[CNT_W-1:0];
        REG_YELLOW:    cfg_r.yellow_sec    <= pwdata[YEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SOUTH_RED: prdata = {{(PDATA_W-CNT_W){1'b0}}, cfg_r.south_red_sec};
      REG_SOUTH_GO:  prdata = {{(PDATA_W-CNT_W){1'b0}}, cfg_r.south_go_sec};
      REG_YELLOW:    prdata = {{(PDATA_W-YEL_W){1'b0}}, cfg_r.yellow_sec};
      default:       prdata = '0;
    endcase
  end

  tlpc_next u_next (
    .state_i  (state_r),
    .cfg_i    (cfg_r),
    .action_i (in_ch.action),
    .auto_i   (in_ch.auto_switch),
    .state_o  (state_nxt),
    .result_o (result_nxt)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.lamps       = result_r.lamps;
  assign out_ch.south_count = result_r.south_count;
  assign out_ch.west_count  = result_r.west_count;
  assign out_ch.display_on  = result_r.display_on;

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_ch.valid)
    else $error("accepted transaction produced no result");

  a_auto_lit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.auto_switch) |=> out_ch.display_on)
    else $error("automatic mode result with blanked displays");

  a_countdown_on_yellow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.man_cnt != '0) |-> !state_r.phase[0])
    else $error("manual countdown running outside a yellow phase");

  a_one_lamp_each: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ($onehot(out_ch.lamps[2:0]) && $onehot(out_ch.lamps[5:3])))
    else $error("street shows other than exactly one lamp");

endmodule

// ===== test/tb_traffic_light_phase_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_traffic_light_phase_controller
// Self-checking bench for the two-way traffic light controller. A queue-fed
// driver offers tick and button events with random gaps. A monitor predicts
// the lamps, countdowns and display blanking of every accepted event and
// compares them with the result channel. The timing registers are rewritten
// between runs while the controller is idle. Repeated long receiver
// hold-offs force the controller to stall its input.
// ----------------------------------------------------------------------------
module tb_traffic_light_phase_controller;
  import tlpc_pkg::*;

  typedef enum logic {ACT_TICK = 1'b0, ACT_PRESS = 1'b1} action_e;
  typedef enum logic {MODE_MANUAL = 1'b0, MODE_AUTO = 1'b1} mode_e;

  typedef struct packed {
    action_e act;
    mode_e   mode;
  } light_event_t;

  localparam logic [1:0] PH_W_YELLOW = 2'd0;
  localparam logic [1:0] PH_S_YELLOW = 2'd2;
  localparam logic [LAMP_W-1:0] LAMP_BY_PHASE [4] =
    '{LAMPS_W_YELLOW, LAMPS_W_GREEN, LAMPS_S_YELLOW, LAMPS_S_GREEN};

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned N_SETTINGS  = 9;
  localparam int unsigned RUN_ITEMS   = 168;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // driven values, known from time zero
  logic               in_valid  = 1'b0;
  logic               in_action = 1'b0;
  logic               in_auto   = 1'b0;
  logic               out_ready = 1'b0;
  logic               psel_r    = 1'b0;
  logic               penable_r = 1'b0;
  logic               pwrite_r  = 1'b0;
  logic [PADDR_W-1:0] paddr_r   = '0;
  logic [PDATA_W-1:0] pwdata_r  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  tlpc_in_if  in_if  (.clk(clk));
  tlpc_out_if out_if (.clk(clk));

  assign in_if.valid       = in_valid;
  assign in_if.action      = in_action;
  assign in_if.auto_switch = in_auto;
  assign out_if.ready      = out_ready;

  traffic_light_phase_controller dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if.sink),
    .out_ch  (out_if.source),
    .psel    (psel_r),
    .penable (penable_r),
    .pwrite  (pwrite_r),
    .paddr   (paddr_r),
    .pwdata  (pwdata_r),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  light_event_t event_q[$];
  tlpc_result_t signal_q[$];

  tlpc_cfg_t   timing = '{SOUTH_RED_RST, SOUTH_GO_RST, YELLOW_RST};
  tlpc_state_t ctl    = '0;

  int unsigned err_count = 0;
  bit          in_fire   = 1'b0;

  // ---------------- controller prediction ----------------

  function void open_half(input logic [1:0] first);
    ctl.phase     = first;
    ctl.half_cnt  = (first == PH_W_YELLOW) ? timing.south_red_sec : timing.south_go_sec;
    ctl.other_cnt = CNT_W'(timing.yellow_sec);
    // no yellow: start straight in green
    if (timing.yellow_sec == '0) begin
      ctl.phase     = ctl.phase + 2'd1;
      ctl.other_cnt = ctl.half_cnt;
    end
  endfunction

  function void count_second();
    if (ctl.half_cnt <= 1) begin
      open_half(ctl.phase < PH_S_YELLOW ? PH_S_YELLOW : PH_W_YELLOW);
    end else begin
      ctl.half_cnt = ctl.half_cnt - 1'b1;
      if (ctl.other_cnt > 0)
        ctl.other_cnt = ctl.other_cnt - 1'b1;
      if (!ctl.phase[0] && ctl.other_cnt == '0) begin
        ctl.phase     = ctl.phase + 2'd1;
        ctl.other_cnt = ctl.half_cnt;
      end
    end
  endfunction

  function tlpc_result_t step_signals(input light_event_t ev);
    tlpc_result_t r;
    logic         press;
    press = (ev.act == ACT_PRESS);
    r = '0;
    if (ev.mode == MODE_AUTO) begin
      if (!ctl.running_auto) begin
        ctl.running_auto = 1'b1;
        ctl.man_cnt      = '0;
        open_half(PH_W_YELLOW);
      end else if (!press) begin
        count_second();
      end
      if (ctl.phase < PH_S_YELLOW) begin
        r.south_count = ctl.half_cnt;
        r.west_count  = ctl.other_cnt;
      end else begin
        r.south_count = ctl.other_cnt;
        r.west_count  = ctl.half_cnt;
      end
      r.display_on = 1'b1;
    end else begin
      if (ctl.running_auto) begin
        ctl.running_auto = 1'b0;
      end else if (ctl.man_cnt > 0) begin
        if (!press) begin
          ctl.man_cnt = ctl.man_cnt - 1'b1;
          if (ctl.man_cnt == '0)
            ctl.phase = ctl.phase + 2'd1;
        end
      end else if (ctl.phase[0]) begin
        if (press)
          ctl.phase = ctl.phase + 2'd1;
      end
      // entering a yellow phase arms the countdown, or goes on to green if the yellow time is zero
      if (ctl.man_cnt == '0 && !ctl.phase[0]) begin
        if (timing.yellow_sec == '0)
          ctl.phase = ctl.phase + 2'd1;
        else
          ctl.man_cnt = timing.yellow_sec;
      end
      if (ctl.man_cnt > 0) begin
        r.south_count = CNT_W'(ctl.man_cnt);
        r.west_count  = CNT_W'(ctl.man_cnt);
        r.display_on  = 1'b1;
      end
    end
    r.lamps = LAMP_BY_PHASE[ctl.phase];
    return r;
  endfunction

  // ---------------- monitor ----------------

  always @(posedge clk) begin : monitor
    tlpc_result_t want;
    in_fire = 1'b0;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        in_fire = 1'b1;
        signal_q.push_back(step_signals('{act: action_e'(in_if.action),
                                          mode: mode_e'(in_if.auto_switch)}));
      end
      if (out_if.valid && out_if.ready) begin
        if (signal_q.size() == 0) begin
          $error("result transaction with nothing outstanding");
          err_count++;
        end else begin
          want = signal_q.pop_front();
          if (out_if.lamps !== want.lamps) begin
            $error("lamps: expected %b, got %b", want.lamps, out_if.lamps);
            err_count++;
          end
          if (out_if.south_count !== want.south_count) begin
            $error("south_count: expected %0d, got %0d", want.south_count, out_if.south_count);
            err_count++;
          end
          if (out_if.west_count !== want.west_count) begin
            $error("west_count: expected %0d, got %0d", want.west_count, out_if.west_count);
            err_count++;
          end
          if (out_if.display_on !== want.display_on) begin
            $error("display_on: expected %b, got %b", want.display_on, out_if.display_on);
            err_count++;
          end
        end
      end
    end
  end

  // ---------------- event driver ----------------

  int unsigned  gap_left    = 0;
  int unsigned  steady_left = 0;
  light_event_t next_ev;

  function int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    if (r < 3) begin
      steady_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // hold the offered transaction
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (event_q.size() > 0) begin
      next_ev = event_q.pop_front();
      in_valid  <= 1'b1;
      in_action <= next_ev.act;
      in_auto   <= next_ev.mode;
      gap_left  <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------- result receiver ----------------

  int unsigned rx_cycles    = 0;
  int unsigned hold_left    = 0;
  int unsigned next_hold_at = 600;

  always @(negedge clk) begin
    rx_cycles <= rx_cycles + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_cycles >= next_hold_at && in_valid) begin
      // long hold-off while events keep coming: fill up and back-pressure
      hold_left    <= 200 + $urandom_range(0, 100);
      next_hold_at <= next_hold_at + 3000;
      out_ready    <= 1'b0;
    end else if ($urandom_range(0, 99) < 75) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end
  end

  // ---------------- watchdog ----------------

  int unsigned cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_traffic_light_phase_controller: done, errors");
      $finish;
    end
  end

  // ---------------- stimulus ----------------

  task automatic add_event(input action_e a, input mode_e m);
    event_q.push_back('{act: a, mode: m});
  endtask

  task automatic add_random_events(input int n);
    int      made;
    int      run;
    int      k;
    int      r;
    mode_e   m;
    action_e a;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        add_event(action_e'($urandom_range(0, 1)), mode_e'($urandom_range(0, 1)));
        made++;
      end else begin
        m   = (r < 60) ? MODE_AUTO : MODE_MANUAL;
        run = (m == MODE_AUTO) ? $urandom_range(4, 90) : $urandom_range(3, 30);
        for (k = 0; k < run && made < n; k++) begin
          a = ($urandom_range(0, 99) < ((m == MODE_AUTO) ? 6 : 35)) ? ACT_PRESS : ACT_TICK;
          add_event(a, m);
          made++;
        end
      end
    end
  endtask

  // check after the edge has settled, so a transaction being offered is seen
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (event_q.size() != 0 || in_valid || signal_q.size() != 0);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [CNT_W-1:0] val);
    @(negedge clk);
    psel_r    <= 1'b1;
    penable_r <= 1'b0;
    pwrite_r  <= 1'b1;
    paddr_r   <= {idx, 2'b00};
    pwdata_r  <= PDATA_W'(val);
    @(negedge clk);
    penable_r <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SOUTH_RED: timing.south_red_sec = val;
      REG_SOUTH_GO:  timing.south_go_sec  = val;
      REG_YELLOW:    timing.yellow_sec    = val[YEL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel_r    <= 1'b0;
    penable_r <= 1'b0;
    pwrite_r  <= 1'b0;
  endtask

  logic [CNT_W-1:0] red_set [N_SETTINGS] = '{5'd31, 5'd4, 5'd0, 5'd2, 5'd31, 5'd5, 5'd1,
                                             5'd0, 5'd0};
  logic [CNT_W-1:0] go_set  [N_SETTINGS] = '{5'd31, 5'd4, 5'd1, 5'd3, 5'd4, 5'd30, 5'd0,
                                             5'd0, 5'd0};
  logic [YEL_W-1:0] yel_set [N_SETTINGS] = '{2'd3, 2'd1, 2'd0, 2'd3, 2'd2, 2'd0, 2'd3,
                                             2'd0, 2'd0};

  initial begin
    int unsigned p;

    // manual from reset: yellow countdown, ignored press, green wait, wrap
    add_event(ACT_TICK,  MODE_MANUAL);
    add_event(ACT_PRESS, MODE_MANUAL);
    add_event(ACT_TICK,  MODE_MANUAL);
    add_event(ACT_TICK,  MODE_MANUAL);
    add_event(ACT_TICK,  MODE_MANUAL);
    add_event(ACT_TICK,  MODE_MANUAL);
    add_event(ACT_PRESS, MODE_MANUAL);
    add_event(ACT_TICK,  MODE_MANUAL);
    add_event(ACT_PRESS, MODE_MANUAL);
    add_event(ACT_TICK,  MODE_MANUAL);
    add_event(ACT_TICK,  MODE_MANUAL);
    add_event(ACT_PRESS, MODE_MANUAL);
    // auto: start consumes a press, presses ignored, ticks count down
    add_event(ACT_PRESS, MODE_AUTO);
    add_event(ACT_PRESS, MODE_AUTO);
    add_event(ACT_TICK,  MODE_AUTO);
    add_event(ACT_TICK,  MODE_AUTO);
    add_event(ACT_TICK,  MODE_AUTO);
    add_event(ACT_TICK,  MODE_AUTO);
    // leave auto in green, then press on from there
    add_event(ACT_PRESS, MODE_MANUAL);
    add_event(ACT_TICK,  MODE_MANUAL);
    add_event(ACT_PRESS, MODE_MANUAL);
    add_event(ACT_TICK,  MODE_MANUAL);
    // restart the cycle
    add_event(ACT_TICK,  MODE_AUTO);
    add_event(ACT_TICK,  MODE_AUTO);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    add_random_events(RUN_ITEMS);

    for (p = 0; p < N_SETTINGS; p++) begin
      wait_idle();
      if (p >= N_SETTINGS - 2) begin
        red_set[p] = CNT_W'($urandom_range(0, 31));
        go_set[p]  = CNT_W'($urandom_range(0, 31));
        yel_set[p] = YEL_W'($urandom_range(0, 3));
      end
      cfg_write(REG_SOUTH_RED, red_set[p]);
      cfg_write(REG_SOUTH_GO,  go_set[p]);
      cfg_write(REG_YELLOW,    CNT_W'(yel_set[p]));
      @(posedge clk);
      add_random_events(RUN_ITEMS);
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (err_count == 0) begin
      $display("tb_traffic_light_phase_controller: done, clean");
    end else begin
      $display("tb_traffic_light_phase_controller: done, errors");
    end
    $finish;
  end

endmodule
